// File: hw/rtl/sdo_pkg.sv
// SDO server package: shared constants, types and result record.
// No dependencies.
package sdo_pkg;

   localparam int BufBytesDefault = 1024;

   localparam logic [1:0] FUNC_FRAME = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_ULEN  = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_RESP  = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [2:0] AB_NONE   = 3'd0;
   localparam logic [2:0] AB_TOGGLE = 3'd1;
   localparam logic [2:0] AB_PARAM  = 3'd2;
   localparam logic [2:0] AB_NOMEM  = 3'd3;
   localparam logic [2:0] AB_BADCMD = 3'd4;

   localparam logic [10:0] COB_BASE = 11'h580;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [6:0]  node;
      logic [9:0]  addr;
      logic [7:0]  data;
      logic [9:0]  ulen;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] cob_id;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [2:0]  reason;
      logic        done;
      logic [9:0]  done_len;
      logic [7:0]  rbyte;
   } result_type;

endpackage

// File: hw/rtl/sdo_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sdo_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// File: hw/rtl/sdo_queue.sv
// Two-entry item queue between the front and back parts.
// Depends on sdo_pkg.
module sdo_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sdo_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output sdo_pkg::item_type out_item
);
   import sdo_pkg::*;

   item_type  slot_ff [2];
   logic      rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_item;
      end
   end
endmodule

// File: hw/rtl/sdo_engine.sv
// Back part: SDO protocol state, byte buffer sequencing and result register.
// Depends on sdo_pkg and sdo_ram.
module sdo_engine #(
   parameter int BufBytes = sdo_pkg::BufBytesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sdo_pkg::item_type   in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output sdo_pkg::result_type out_res
);
   import sdo_pkg::*;

   localparam int AW = $clog2(BufBytes);
   localparam logic [9:0] MaxLen = (BufBytes - 1 > 1023) ? 10'd1023 : 10'(BufBytes - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DEC   = 3'd1;
   localparam logic [2:0] ST_BYTE  = 3'd2;
   localparam logic [2:0] ST_LAST  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]  st_ff;
   item_type    it_ff;
   result_type  res_ff;
   logic        ov_ff;
   logic        act_ff, tog_ff;
   logic [2:0]  exp_ff;
   logic [9:0]  tot_ff, cnt_ff, ulen_ff;
   logic [15:0] idx_ff;
   logic [7:0]  sub_ff;
   // byte sequencer
   logic [2:0]  k_ff;        // current byte step
   logic [2:0]  n_ff;        // number of bytes
   logic        wr_ff;       // write (1) or read (0) sequence
   logic [10:0] base_ff;     // buffer address of step 0
   logic [2:0]  sh_ff;       // byte lane offset in result
   logic [63:0] acc_ff;
   logic        pend_ff;     // read data of previous step pending
   logic [2:0]  pk_ff;
   logic        pok_ff;

   logic          we;
   logic [AW-1:0] ra;
   logic [7:0]    wd, rd;
   logic [10:0]   a_full;
   logic          a_ok;
   logic [63:0]   frame;
   logic [7:0]    cmd;
   logic [2:0]    cs;

   assign frame = {it_ff.w1, it_ff.w0};
   assign cmd   = it_ff.w0[7:0];
   assign cs    = cmd[7:5];
   assign in_ready  = (st_ff == ST_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;

   // buffer address of the current step
   always_comb begin
      a_full = base_ff + {8'd0, k_ff};
      a_ok   = ({21'd0, a_full} < 32'(BufBytes));
      ra     = AW'(a_full);
      we     = (st_ff == ST_BYTE) && wr_ff && a_ok && (k_ff < n_ff);
      wd     = frame[{sh_ff + k_ff, 3'b000} +: 8];
   end

   sdo_ram #(.Width(8), .Depth(BufBytes)) u_ram (
      .clock(clock), .we(we), .addr(ra), .wdata(wd), .rdata(rd)
   );

   function automatic logic [31:0] head(input logic [7:0] c, input logic [15:0] ix,
                                        input logic [7:0] sb);
      return {sb, ix, c};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         ov_ff   <= 1'b0;
         act_ff  <= 1'b0;
         exp_ff  <= 3'd0;
         tog_ff  <= 1'b0;
         tot_ff  <= 10'd0;
         cnt_ff  <= 10'd0;
         idx_ff  <= 16'd0;
         sub_ff  <= 8'd0;
         ulen_ff <= 10'd0;
         pend_ff <= 1'b0;
      end else begin
         if (ov_ff && out_ready) begin
            ov_ff <= 1'b0;
         end
         unique case (st_ff)
            ST_IDLE: begin
               if (in_valid && in_ready) begin
                  it_ff <= in_item;
                  st_ff <= ST_DEC;
               end
            end
            ST_DEC: begin
               res_ff        <= '0;
               res_ff.cob_id <= COB_BASE + {4'd0, it_ff.node};
               k_ff    <= 3'd0;
               n_ff    <= 3'd0;
               wr_ff   <= 1'b0;
               sh_ff   <= 3'd0;
               acc_ff  <= '0;
               pend_ff <= 1'b0;
               st_ff   <= ST_LAST;
               case (it_ff.func)
                  FUNC_WRITE: begin
                     res_ff.cob_id <= '0;
                     if ({22'd0, it_ff.addr} < 32'(BufBytes)) begin
                        it_ff.w0 <= {24'd0, it_ff.data};
                        base_ff <= {1'b0, it_ff.addr};
                        sh_ff <= 3'd0; n_ff <= 3'd1; wr_ff <= 1'b1;
                        st_ff <= ST_BYTE;
                     end
                  end
                  FUNC_READ: begin
                     res_ff.cob_id <= '0;
                     res_ff.kind <= KIND_READ;
                     base_ff <= {1'b0, it_ff.addr};
                     sh_ff <= 3'd0; n_ff <= 3'd1;
                     st_ff <= ST_BYTE;
                  end
                  FUNC_ULEN: begin
                     res_ff.cob_id <= '0;
                     ulen_ff <= it_ff.ulen;
                  end
                  default: begin
                     if (!act_ff) begin
                        idx_ff <= it_ff.w0[23:8];
                        sub_ff <= it_ff.w0[31:24];
                        tog_ff <= 1'b0;
                        res_ff.kind <= KIND_RESP;
                        if (cs == 3'd1) begin
                           res_ff.w0 <= head(8'h60, it_ff.w0[23:8], it_ff.w0[31:24]);
                           if (cmd[1]) begin
                              res_ff.done <= 1'b1;
                              res_ff.done_len <= cmd[0] ? 10'(3'd4 - {1'b0, cmd[3:2]})
                                                        : 10'd4;
                              base_ff <= 11'd0; sh_ff <= 3'd4; n_ff <= 3'd4;
                              wr_ff <= 1'b1; st_ff <= ST_BYTE;
                           end else if (cmd[0] && it_ff.w1 > {22'd0, MaxLen}) begin
                              act_ff <= 1'b0;
                              res_ff.kind <= KIND_ABORT;
                              res_ff.reason <= AB_NOMEM;
                              res_ff.w0 <= head(8'h80, it_ff.w0[23:8], it_ff.w0[31:24]);
                           end else begin
                              tot_ff <= cmd[0] ? it_ff.w1[9:0] : MaxLen;
                              cnt_ff <= 10'd0;
                              act_ff <= 1'b1;
                              exp_ff <= 3'd0;
                           end
                        end else if (cs == 3'd2) begin
                           tot_ff <= ulen_ff;
                           if (ulen_ff <= 10'd4) begin
                              res_ff.w0 <= head(8'h43 + {4'd0, 2'(3'd4 - ulen_ff[2:0]), 2'b00},
                                                it_ff.w0[23:8], it_ff.w0[31:24]);
                              base_ff <= 11'd0; sh_ff <= 3'd4; n_ff <= ulen_ff[2:0];
                              st_ff <= ST_BYTE;
                           end else begin
                              res_ff.w0 <= head(8'h41, it_ff.w0[23:8], it_ff.w0[31:24]);
                              res_ff.w1 <= {22'd0, ulen_ff};
                              act_ff <= 1'b1;
                              cnt_ff <= 10'd0;
                              exp_ff <= 3'd3;
                           end
                        end else begin
                           act_ff <= 1'b0;
                           res_ff.kind <= KIND_ABORT;
                           res_ff.reason <= AB_PARAM;
                           res_ff.w0 <= head(8'h80, it_ff.w0[23:8], it_ff.w0[31:24]);
                        end
                     end else if (cs != exp_ff) begin
                        act_ff <= 1'b0;
                        res_ff.kind <= KIND_ABORT;
                        res_ff.reason <= AB_BADCMD;
                        res_ff.w0 <= head(8'h80, idx_ff, sub_ff);
                     end else if (cs == 3'd0) begin
                        if (cmd[4] != tog_ff) begin
                           act_ff <= 1'b0;
                           res_ff.kind <= KIND_ABORT;
                           res_ff.reason <= AB_TOGGLE;
                           res_ff.w0 <= head(8'h80, idx_ff, sub_ff);
                        end else if (cnt_ff > tot_ff ||
                                     {7'd0, 3'd7 - cmd[3:1]} > tot_ff - cnt_ff) begin
                           act_ff <= 1'b0;
                           res_ff.kind <= KIND_ABORT;
                           res_ff.reason <= AB_PARAM;
                           res_ff.w0 <= head(8'h80, idx_ff, sub_ff);
                        end else begin
                           res_ff.kind <= KIND_RESP;
                           res_ff.w0 <= {24'd0, 3'b001, tog_ff, 4'd0};
                           tog_ff <= ~tog_ff;
                           base_ff <= {1'b0, cnt_ff}; sh_ff <= 3'd1;
                           n_ff <= 3'd7 - cmd[3:1]; wr_ff <= 1'b1;
                           cnt_ff <= cnt_ff + {7'd0, 3'd7 - cmd[3:1]};
                           if (cmd[0]) begin
                              tot_ff <= cnt_ff + {7'd0, 3'd7 - cmd[3:1]};
                              act_ff <= 1'b0;
                              res_ff.done <= 1'b1;
                              res_ff.done_len <= cnt_ff + {7'd0, 3'd7 - cmd[3:1]};
                           end
                           st_ff <= ST_BYTE;
                        end
                     end else begin
                        // upload segment
                        res_ff.kind <= KIND_RESP;
                        tog_ff <= ~tog_ff;
                        base_ff <= {1'b0, cnt_ff}; sh_ff <= 3'd1;
                        if (cnt_ff > tot_ff || tot_ff - cnt_ff <= 10'd7) begin
                           logic [2:0] r;
                           r = (cnt_ff > tot_ff) ? 3'd0 : 3'(tot_ff - cnt_ff);
                           acc_ff[7:0] <= {3'd0, tog_ff, 3'd7 - r, 1'b1};
                           n_ff <= r;
                           cnt_ff <= cnt_ff + {7'd0, r};
                           act_ff <= 1'b0;
                        end else begin
                           acc_ff[7:0] <= {3'd0, tog_ff, 4'd0};
                           n_ff <= 3'd7;
                           cnt_ff <= cnt_ff + 10'd7;
                        end
                        st_ff <= ST_BYTE;
                     end
                  end
               endcase
            end
            ST_BYTE: begin
               // one buffer byte per cycle, read data lands in the following cycle
               pend_ff <= !wr_ff && (k_ff < n_ff);
               pk_ff   <= k_ff;
               pok_ff  <= a_ok;
               if (pend_ff && pok_ff) begin
                  acc_ff[{sh_ff + pk_ff, 3'b000} +: 8] <= rd;
               end
               if (k_ff >= n_ff) begin
                  st_ff <= ST_LAST;
               end else begin
                  k_ff <= k_ff + 3'd1;
               end
            end
            ST_LAST: begin
               if (pend_ff && pok_ff) begin
                  acc_ff[{sh_ff + pk_ff, 3'b000} +: 8] <= rd;
               end
               pend_ff <= 1'b0;
               st_ff   <= ST_OUT;
            end
            ST_OUT: begin
               if (!ov_ff) begin
                  if (!wr_ff && res_ff.kind == KIND_READ) begin
                     res_ff.rbyte <= acc_ff[7:0];
                  end else if (!wr_ff && res_ff.kind == KIND_RESP && n_ff != 3'd0 &&
                               sh_ff == 3'd4) begin
                     res_ff.w1 <= acc_ff[63:32];
                  end else if (!wr_ff && res_ff.kind == KIND_RESP && sh_ff == 3'd1) begin
                     res_ff.w0 <= acc_ff[31:0];
                     res_ff.w1 <= acc_ff[63:32];
                  end
                  ov_ff <= 1'b1;
                  st_ff <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: hw/rtl/sdo_segmented_transfer_server.sv
// SDO server top level: input queue feeding the protocol engine.
// Depends on sdo_pkg, sdo_queue, sdo_engine.
//
// Usage: one item per req_ transfer. func selects a client frame, a local
// buffer byte write, a local buffer byte read or setting the upload length.
// Exactly one result per item leaves on the rsp_ channel, in order; kind 0
// results (local writes and length updates) are delivered like any other.
// Flow: an item passes through the queue, a decode state, the steps through
// the single-port byte buffer (one byte per cycle), a last state and an
// output state. Items are paced by the byte-buffer port and by the engine
// waiting for its result to be taken before it takes the next item.
// A two-entry queue keeps accepting items, while it has room, as the engine
// works or the result register waits for rsp_ready; the engine holds its
// finished result until it is taken and takes no new item meanwhile.
// Reset clears the protocol state and queue; buffer contents stay
// undefined until written.
module sdo_segmented_transfer_server #(
   parameter int BufBytes = sdo_pkg::BufBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_frame_word0,
   input  logic [31:0] req_frame_word1,
   input  logic [6:0]  req_node_id,
   input  logic [9:0]  req_buf_addr,
   input  logic [7:0]  req_buf_byte,
   input  logic [9:0]  req_upload_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [10:0] rsp_cob_id,
   output logic [31:0] rsp_resp_word0,
   output logic [31:0] rsp_resp_word1,
   output logic [2:0]  rsp_abort_reason,
   output logic        rsp_download_done,
   output logic [9:0]  rsp_done_length,
   output logic [7:0]  rsp_read_byte
);
   import sdo_pkg::*;

   item_type   req_item, q_item;
   result_type res;
   logic       q_valid, q_ready;

   assign req_item = '{func: req_func, w0: req_frame_word0, w1: req_frame_word1,
                       node: req_node_id, addr: req_buf_addr, data: req_buf_byte,
                       ulen: req_upload_len};

   sdo_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_item(req_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   sdo_engine #(.BufBytes(BufBytes)) u_engine (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_res(res)
   );

   assign rsp_kind          = res.kind;
   assign rsp_cob_id        = res.cob_id;
   assign rsp_resp_word0    = res.w0;
   assign rsp_resp_word1    = res.w1;
   assign rsp_abort_reason  = res.reason;
   assign rsp_download_done = res.done;
   assign rsp_done_length   = res.done_len;
   assign rsp_read_byte     = res.rbyte;
endmodule

// File: tb/tb_sdo_segmented_transfer_server.sv
// Testbench for the SDO segmented transfer server: directed and random client frames
// and local buffer accesses, each checked against an in-bench protocol predictor.
// Depends on sdo_pkg and sdo_segmented_transfer_server.
`timescale 1ns / 1ps

module tb_sdo_segmented_transfer_server;
   import sdo_pkg::*;

   localparam int BUFN = 1024;

   // command specifier field values
   localparam logic [2:0] CS_DL_SEG  = 3'd0;
   localparam logic [2:0] CS_DL_INIT = 3'd1;
   localparam logic [2:0] CS_UL_INIT = 3'd2;
   localparam logic [2:0] CS_UL_SEG  = 3'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [31:0] req_frame_word0 = '0;
   logic [31:0] req_frame_word1 = '0;
   logic [6:0]  req_node_id = '0;
   logic [9:0]  req_buf_addr = '0;
   logic [7:0]  req_buf_byte = '0;
   logic [9:0]  req_upload_len = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [10:0] rsp_cob_id;
   logic [31:0] rsp_resp_word0;
   logic [31:0] rsp_resp_word1;
   logic [2:0]  rsp_abort_reason;
   logic        rsp_download_done;
   logic [9:0]  rsp_done_length;
   logic [7:0]  rsp_read_byte;

   sdo_segmented_transfer_server u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic        srv_active;
   logic [2:0]  srv_exp_cs;
   logic        srv_toggle;
   int unsigned srv_total;
   int unsigned srv_count;
   logic [15:0] srv_index;
   logic [7:0]  srv_sub;
   int unsigned srv_ulen;
   logic [7:0]  srv_buf [BUFN];
   bit          srv_written [BUFN];

   item_type   pending_items[$];
   result_type expected_results[$];
   int         fail_count = 0;
   int         checked = 0;
   int         frames_sent = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       req_taken = 1'b0;
   bit         hold_req = 1'b0;
   bit         hold_done = 1'b0;
   int         hold_cnt = 0;

   function automatic logic [31:0] head_word(input logic [7:0] cmd);
      return {srv_sub, srv_index, cmd};
   endfunction

   function automatic result_type sdo_abort(input logic [6:0] node, input logic [2:0] why);
      result_type r;
      r = '0;
      srv_active = 1'b0;
      r.kind = KIND_ABORT;
      r.cob_id = COB_BASE + {4'd0, node};
      r.w0 = head_word(8'h80);
      r.reason = why;
      return r;
   endfunction

   // compute the response of the server to one item
   function automatic result_type predict_response(input item_type it);
      result_type r;
      logic [63:0] frame, data;
      logic [7:0]  cmd, c;
      logic [2:0]  cs;
      int unsigned rest, inmsg, n;
      r = '0;
      case (it.func)
         FUNC_WRITE: begin
            srv_buf[it.addr] = it.data;
            srv_written[it.addr] = 1'b1;
         end
         FUNC_READ: begin
            r.kind = KIND_READ;
            r.rbyte = srv_buf[it.addr];
         end
         FUNC_ULEN: srv_ulen = 32'(it.ulen);
         default: begin
            frame = {it.w1, it.w0};
            cmd = it.w0[7:0];
            cs = cmd[7:5];
            r.cob_id = COB_BASE + {4'd0, it.node};
            r.kind = KIND_RESP;
            if (!srv_active) begin
               srv_index = it.w0[23:8];
               srv_sub = it.w0[31:24];
               srv_toggle = 1'b0;
               if (cs == CS_DL_INIT) begin
                  if (cmd[1]) begin
                     for (int i = 0; i < 4; i++) begin
                        srv_buf[i] = it.w1[8*i +: 8];
                        srv_written[i] = 1'b1;
                     end
                     r.w0 = head_word(8'h60);
                     r.done = 1'b1;
                     r.done_len = cmd[0] ? 10'(4 - cmd[3:2]) : 10'd4;
                     return r;
                  end
                  if (cmd[0]) begin
                     if (it.w1 > BUFN - 1) return sdo_abort(it.node, AB_NOMEM);
                     srv_total = it.w1;
                  end else srv_total = BUFN - 1;
                  srv_count = 0;
                  srv_active = 1'b1;
                  srv_exp_cs = CS_DL_SEG;
                  r.w0 = head_word(8'h60);
                  return r;
               end
               if (cs == CS_UL_INIT) begin
                  srv_total = srv_ulen;
                  if (srv_ulen <= 4) begin
                     data = '0;
                     for (int i = 0; i < srv_ulen; i++) data[8*i +: 8] = srv_buf[i];
                     r.w0 = head_word(8'(8'h43 + (((4 - srv_ulen) << 2) & 8'hc)));
                     r.w1 = data[31:0];
                  end else begin
                     r.w0 = head_word(8'h41);
                     r.w1 = srv_ulen;
                     srv_active = 1'b1;
                     srv_count = 0;
                     srv_exp_cs = CS_UL_SEG;
                  end
                  return r;
               end
               return sdo_abort(it.node, AB_PARAM);
            end
            if (cs != srv_exp_cs) return sdo_abort(it.node, AB_BADCMD);
            if (cs == CS_DL_SEG) begin
               if (cmd[4] != srv_toggle) return sdo_abort(it.node, AB_TOGGLE);
               if (srv_count > srv_total) return sdo_abort(it.node, AB_PARAM);
               rest = srv_total - srv_count;
               inmsg = 7 - cmd[3:1];
               if (inmsg > rest) return sdo_abort(it.node, AB_PARAM);
               for (int i = 0; i < inmsg; i++) begin
                  n = srv_count + i;
                  if (n < BUFN) begin
                     srv_buf[n] = frame[8*(i+1) +: 8];
                     srv_written[n] = 1'b1;
                  end
               end
               srv_count += inmsg;
               r.w0 = {24'd0, 8'h20 | {3'd0, srv_toggle, 4'd0}};
               srv_toggle ^= 1'b1;
               if (cmd[0]) begin
                  srv_total = srv_count;
                  srv_active = 1'b0;
                  r.done = 1'b1;
                  r.done_len = srv_count[9:0];
               end
               return r;
            end
            // upload segment
            rest = (srv_count > srv_total) ? 0 : srv_total - srv_count;
            if (rest <= 7) begin
               c = 8'((srv_toggle << 4) + 1 + ((7 - rest) << 1));
               srv_active = 1'b0;
            end else begin
               c = {3'd0, srv_toggle, 4'd0};
               rest = 7;
            end
            srv_toggle ^= 1'b1;
            data = '0;
            for (int i = 0; i < rest; i++) begin
               n = srv_count + i;
               data[8*(i+1) +: 8] = (n < BUFN) ? srv_buf[n] : 8'h00;
            end
            srv_count += rest;
            data[7:0] = data[7:0] | c;
            r.w0 = data[31:0];
            r.w1 = data[63:32];
         end
      endcase
      return r;
   endfunction

   // item builders; the predictor runs at queueing time in stimulus order
   task automatic push_item(input item_type it);
      expected_results.push_back(predict_response(it));
      pending_items.push_back(it);
   endtask

   task automatic push_frame(input logic [31:0] w0, input logic [31:0] w1);
      item_type it;
      it = '0;
      it.func = FUNC_FRAME;
      it.w0 = w0;
      it.w1 = w1;
      it.node = 7'($urandom_range(0, 127));
      it.addr = 10'($urandom);
      it.data = 8'($urandom);
      it.ulen = 10'($urandom);
      push_item(it);
      frames_sent++;
   endtask

   task automatic push_local(input logic [1:0] f, input logic [9:0] a, input logic [7:0] d,
                             input logic [9:0] l);
      item_type it;
      it.func = f;
      it.w0 = $urandom;
      it.w1 = $urandom;
      it.node = 7'($urandom);
      it.addr = a;
      it.data = d;
      it.ulen = l;
      push_item(it);
   endtask

   // fill a buffer range so later uploads never read unwritten bytes
   task automatic fill_buffer(input int n);
      for (int a = 0; a < n && a < BUFN; a++)
         if (!srv_written[a]) push_local(FUNC_WRITE, 10'(a), 8'($urandom), 10'($urandom));
   endtask

   task automatic random_local();
      int unsigned a;
      int sel;
      sel = $urandom_range(0, 2);
      a = $urandom_range(0, BUFN - 1);
      if (sel == 0) push_local(FUNC_WRITE, 10'(a), 8'($urandom), 10'($urandom));
      else if (sel == 1 && srv_written[a])
         push_local(FUNC_READ, 10'(a), 8'($urandom), 10'($urandom));
      else push_local(FUNC_ULEN, 10'($urandom_range(0, 40)), 8'($urandom),
                      10'($urandom_range(0, 40)));
   endtask

   // one well-formed transfer with random content, sometimes broken
   task automatic random_transfer();
      logic [31:0] hdr, w0, w1;
      logic [7:0]  cmd;
      int unsigned len, left, k;
      bit tg;
      hdr = {$urandom} & 32'hffffff00;
      case ($urandom_range(0, 5))
         0: begin
            cmd = {CS_DL_INIT, 1'b0, 2'($urandom), 1'b1, 1'($urandom)};
            push_frame(hdr | cmd, $urandom);
         end
         1, 2: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100) : $urandom_range(0, 40);
            cmd = {CS_DL_INIT, 1'b0, 2'd0, 1'b0, 1'b1};
            if ($urandom_range(0, 9) == 0) cmd[0] = 1'b0;
            push_frame(hdr | cmd, len);
            left = (cmd[0]) ? len : $urandom_range(0, 30);
            tg = 1'b0;
            while (srv_active) begin
               k = (left > 7) ? 7 : left;
               if ($urandom_range(0, 3) == 0) k = $urandom_range(0, (left < 7) ? left : 7);
               left -= k;
               cmd = {CS_DL_SEG, tg, 3'(7 - k),
                      left == 0 ? 1'b1 : 1'($urandom_range(0, 5) == 0)};
               if ($urandom_range(0, 29) == 0) cmd[4] = ~cmd[4];
               if ($urandom_range(0, 29) == 0) cmd[7:5] = 3'($urandom);
               if ($urandom_range(0, 39) == 0) cmd[3:1] = 3'd0;
               push_frame({$urandom} & 32'hffffff00 | cmd, $urandom);
               tg = ~tg;
               if (srv_active && $urandom_range(0, 15) == 0) random_local();
               if (srv_count >= srv_total && srv_active && cmd[0] == 1'b0 && left == 0) begin
                  push_frame({$urandom} & 32'hffffff00 | {CS_DL_SEG, tg, 3'd7, 1'b1}, $urandom);
               end
            end
         end
         3, 4: begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 160)
                                               : $urandom_range(0, 40);
            fill_buffer(int'(len));
            push_local(FUNC_ULEN, 10'($urandom), 8'($urandom), 10'(len));
            push_frame(hdr | {CS_UL_INIT, 5'($urandom)}, $urandom);
            while (srv_active) begin
               cmd = {CS_UL_SEG, 5'($urandom)};
               if ($urandom_range(0, 39) == 0) cmd[7:5] = 3'($urandom);
               push_frame({$urandom} & 32'hffffff00 | cmd, $urandom);
            end
         end
         default: begin
            // noise: arbitrary frame or local access
            if ($urandom_range(0, 1) && !srv_active) begin
               w0 = $urandom;
               w1 = $urandom;
               if (w0[7:5] == CS_UL_INIT) fill_buffer(srv_ulen <= 4 ? int'(srv_ulen) : 0);
               if (!(w0[7:5] == CS_UL_INIT && srv_ulen > 4)) push_frame(w0, w1);
               else random_local();
            end else random_local();
         end
      endcase
   endtask

   // input transfer seen at the rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // driver: falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) void'(pending_items.pop_front());
         if (!req_valid || req_taken) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_func <= pending_items[0].func;
               req_frame_word0 <= pending_items[0].w0;
               req_frame_word1 <= pending_items[0].w1;
               req_node_id <= pending_items[0].node;
               req_buf_addr <= pending_items[0].addr;
               req_buf_byte <= pending_items[0].data;
               req_upload_len <= pending_items[0].ulen;
            end else req_valid <= 1'b0;
         end
      end
   end

   // receiver: random ready, plus one long hold-off counted here
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 299;
            rsp_ready <= 1'b0;
         end else if (hold_cnt > 0) begin
            rsp_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
         end else rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: rising edge
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result kind=%0d w0=%h", $time, rsp_kind, rsp_resp_word0);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            checked++;
            if (rsp_kind !== e.kind || rsp_cob_id !== e.cob_id || rsp_resp_word0 !== e.w0 ||
                rsp_resp_word1 !== e.w1 || rsp_abort_reason !== e.reason ||
                rsp_download_done !== e.done || rsp_done_length !== e.done_len ||
                rsp_read_byte !== e.rbyte) begin
               $display({"%0t: mismatch expected kind=%0d cob=%h w0=%h w1=%h ab=%0d",
                         " dn=%0d len=%0d rb=%h"},
                        $time, e.kind, e.cob_id, e.w0, e.w1, e.reason, e.done, e.done_len,
                        e.rbyte);
               $display({"%0t:          actual   kind=%0d cob=%h w0=%h w1=%h ab=%0d",
                         " dn=%0d len=%0d rb=%h"},
                        $time, rsp_kind, rsp_cob_id, rsp_resp_word0, rsp_resp_word1,
                        rsp_abort_reason, rsp_download_done, rsp_done_length, rsp_read_byte);
               fail_count++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clock);
   endtask

   initial begin
      srv_active = 1'b0; srv_exp_cs = '0; srv_toggle = 1'b0; srv_total = 0; srv_count = 0;
      srv_index = '0; srv_sub = '0; srv_ulen = 0;
      for (int i = 0; i < BUFN; i++) begin
         srv_buf[i] = 8'h00;
         srv_written[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: expedited download, extremes, reads, uploads, aborts
      push_frame(32'hffffff23, 32'hffffffff);
      push_frame(32'h0000002f, 32'h00000000);
      push_frame(32'h12345622, 32'ha5a55a5a);
      push_local(FUNC_READ, 10'd0, 8'h00, 10'd0);
      push_local(FUNC_READ, 10'd3, 8'h00, 10'd0);
      push_local(FUNC_WRITE, 10'h3ff, 8'hff, 10'h3ff);
      push_local(FUNC_READ, 10'h3ff, 8'h00, 10'd0);
      push_frame(32'h00100021, 32'd1024);
      push_frame(32'h00100021, 32'hffffffff);
      push_frame(32'h000000e0, 32'h0);
      push_frame(32'h000000a0, 32'h0);
      push_local(FUNC_ULEN, 10'd0, 8'd0, 10'd0);
      push_frame(32'h00200040, 32'h0);
      push_local(FUNC_ULEN, 10'd0, 8'd0, 10'd3);
      push_frame(32'h00200040, 32'h0);
      push_frame(32'h00300021, 32'd9);
      push_frame(32'h00000010, 32'h0);
      push_frame(32'h00300021, 32'd9);
      push_frame(32'h00000060, 32'h0);
      push_frame(32'h00300021, 32'd3);
      push_frame(32'h00000000, 32'h0);
      push_frame(32'h00300020, 32'h0);
      push_frame(32'hffffff00, 32'hffffffff);
      push_frame(32'h00000001, 32'h0);
      drain();

      // random phases with different idling
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 33 : 0;
         recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 33 : 0;
         if (ph == 4) hold_req = 1'b1;
         while (pending_items.size() < 365) random_transfer();
         drain();
      end

      repeat (30) @(posedge clock);
      $display("Checked %0d results from %0d client frames plus local accesses.", checked,
               frames_sent);
      $display("Phases covered free-running, sender idle, receiver stall, mixed and long hold-off.");
      if (fail_count == 0) $display("tb_sdo_segmented_transfer_server: PASS");
      else $display("tb_sdo_segmented_transfer_server: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_sdo_segmented_transfer_server: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sdo_pkg.sv
hw/rtl/sdo_ram.sv
hw/rtl/sdo_queue.sv
hw/rtl/sdo_engine.sv
hw/rtl/sdo_segmented_transfer_server.sv
tb/tb_sdo_segmented_transfer_server.sv
